// ===== rtl/pcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcr_pkg;

  // Fixed field widths
  localparam int POS_WIDTH       = 32;
  localparam int TURN_BITS_DEF   = 16;
  localparam int INTEG_WIDTH_DEF = 48;
  localparam int DT_W            = 24;
  localparam int CUR_W           = 32;
  localparam int GAIN_W          = 32;
  localparam int LIM_W           = 47;

  // Configuration port
  localparam int CFG_DW = 47;
  localparam int CFG_AW = 3;

  // Shared multiplier and accumulator
  localparam int MUL_W     = 32;
  localparam int OPB_W     = 2 * MUL_W;
  localparam int ACC_W     = MUL_W + OPB_W + 2;
  localparam int SAT_W     = 64;
  localparam int SUM_W     = SAT_W + 1;
  localparam int OUT_SHIFT = 24;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PROP_GAIN    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_INTEG_GAIN   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_INTEG_LIMIT  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CURRENT_LOW  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CURRENT_HIGH = 3'd5;
  localparam logic [CFG_AW-1:0] REG_WRAP_ERROR   = 3'd6;
  localparam logic [CFG_AW-1:0] REG_HOLD_CURRENT = 3'd7;

  // Mode codes
  localparam logic [1:0] MODE_SERVO     = 2'd0;
  localparam logic [1:0] MODE_HOLD_REG  = 2'd1;
  localparam logic [1:0] MODE_HOLD_LAST = 2'd2;

  typedef struct packed {
    logic                        op;
    logic signed [POS_WIDTH-1:0] position_ref;
    logic signed [POS_WIDTH-1:0] position_meas;
    logic                        ref_valid;
    logic                        meas_valid;
    logic [DT_W-1:0]             sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] current_ref;
    logic                    sat_high;
    logic                    sat_low;
    logic                    fallback;
  } out_item_t;

  // What a word asks of the block
  typedef enum logic [2:0] {
    K_CLEAR,
    K_STALE,
    K_HOLD_REG,
    K_HOLD_LAST,
    K_INVALID,
    K_SERVO
  } kind_t;

  // Datapath register step
  typedef enum logic [2:0] {
    ST_NONE,
    ST_ERR,
    ST_EMAG,
    ST_PSAT,
    ST_IADD,
    ST_ICLAMP,
    ST_PMAG,
    ST_CLAMP
  } dp_step_t;

  typedef enum logic [1:0] {
    MA_DT,
    MA_KP,
    MA_KI
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_ERR_LO,
    MB_ERR_HI,
    MB_PROP_LO,
    MB_PROP_HI
  } mul_b_t;

  typedef struct packed {
    logic     load_in;
    dp_step_t step;
    logic     mul_en;
    mul_a_t   a_sel;
    mul_b_t   b_sel;
    logic     acc_add;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ERR,
    S_EMAG,
    S_M0,
    S_M1,
    S_M2,
    S_PSAT,
    S_IADD,
    S_ICLAMP,
    S_PMAG,
    S_Q1,
    S_Q2,
    S_Q3,
    S_Q4,
    S_CLAMP,
    S_FIN,
    S_SIMPLE
  } ctrl_state_t;

endpackage

`default_nettype wire

// ===== rtl/pcr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_ready,
  input  wire pcr_pkg::dp_stat_t stat,
  output logic                   in_ready,
  output logic                   out_valid,
  output pcr_pkg::dp_cmd_t       cmd
);
  import pcr_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        can_load;

  // Output register is free, or is being emptied this cycle
  assign can_load  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_ERR;
      S_ERR:    state_nxt = (stat.kind == K_SERVO) ? S_EMAG : S_SIMPLE;
      S_EMAG:   state_nxt = S_M0;
      S_M0:     state_nxt = S_M1;
      S_M1:     state_nxt = S_M2;
      S_M2:     state_nxt = S_PSAT;
      S_PSAT:   state_nxt = S_IADD;
      S_IADD:   state_nxt = S_ICLAMP;
      S_ICLAMP: state_nxt = S_PMAG;
      S_PMAG:   state_nxt = S_Q1;
      S_Q1:     state_nxt = S_Q2;
      S_Q2:     state_nxt = S_Q3;
      S_Q3:     state_nxt = S_Q4;
      S_Q4:     state_nxt = S_CLAMP;
      S_CLAMP:  state_nxt = S_FIN;
      S_FIN, S_SIMPLE: begin
        if (can_load) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd         = '0;
    cmd.step    = ST_NONE;
    cmd.a_sel   = MA_DT;
    cmd.b_sel   = MB_ERR_LO;
    unique case (state_r)
      S_IDLE:   cmd.load_in = in_valid;
      S_ERR:    cmd.step = ST_ERR;
      S_EMAG:   cmd.step = ST_EMAG;
      S_M0: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = MA_DT;
        cmd.b_sel  = MB_ERR_LO;
      end
      S_M1: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.a_sel   = MA_DT;
        cmd.b_sel   = MB_ERR_HI;
      end
      S_M2:     cmd.acc_add = 1'b1;
      S_PSAT:   cmd.step = ST_PSAT;
      S_IADD:   cmd.step = ST_IADD;
      S_ICLAMP: cmd.step = ST_ICLAMP;
      S_PMAG: begin
        cmd.step   = ST_PMAG;
        cmd.mul_en = 1'b1;
        cmd.a_sel  = MA_KP;
        cmd.b_sel  = MB_ERR_LO;
      end
      S_Q1: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.a_sel   = MA_KP;
        cmd.b_sel   = MB_ERR_HI;
      end
      S_Q2: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.a_sel   = MA_KI;
        cmd.b_sel   = MB_PROP_LO;
      end
      S_Q3: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.a_sel   = MA_KI;
        cmd.b_sel   = MB_PROP_HI;
      end
      S_Q4:     cmd.acc_add = 1'b1;
      S_CLAMP:  cmd.step = ST_CLAMP;
      S_FIN, S_SIMPLE: cmd.commit = can_load;
      default:  cmd.load_in = 1'b0;
    endcase
  end

  // Set on a new result, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcr_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcr_dpath #(
  parameter int TURN_BITS   = pcr_pkg::TURN_BITS_DEF,
  parameter int INTEG_WIDTH = pcr_pkg::INTEG_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [pcr_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [pcr_pkg::CFG_DW-1:0]  cfg_wdata,
  input  wire pcr_pkg::in_item_t           in_data,
  input  wire pcr_pkg::dp_cmd_t            cmd,
  output pcr_pkg::dp_stat_t                stat,
  output pcr_pkg::out_item_t               out_data
);
  import pcr_pkg::*;

  localparam int IW      = INTEG_WIDTH;
  localparam int EW      = (POS_WIDTH + 1 > TURN_BITS) ? POS_WIDTH + 1 : TURN_BITS;
  localparam int WRAP_SH = EW - TURN_BITS;
  localparam int BW      = ((IW > LIM_W) ? IW : LIM_W) + 1;

  localparam logic signed [IW-1:0]    IMAX  = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0]    IMIN  = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [SAT_W-1:0] S_MAX = {1'b0, {(SAT_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] S_MIN = {1'b1, {(SAT_W-1){1'b0}}};

  function automatic logic signed [CUR_W-1:0] clamp_cur(
    input logic signed [CUR_W-1:0] v,
    input logic signed [CUR_W-1:0] lo,
    input logic signed [CUR_W-1:0] hi
  );
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Configuration registers
  logic [1:0]               mode_r;
  logic signed [GAIN_W-1:0] kp_r, ki_r;
  logic [LIM_W-1:0]         lim_r;
  logic signed [CUR_W-1:0]  cur_a_r, cur_b_r, hold_r;
  logic                     wrap_r;

  // Working registers
  in_item_t                 in_r;
  kind_t                    kind;
  logic signed [EW-1:0]     err_r, err_nxt, diff, diff_wrap;
  logic [EW-1:0]            emag_r;
  logic                     eneg_r;
  logic signed [CUR_W-1:0]  cmin_r, cmax_r;
  logic signed [IW-1:0]     ilo_r, ihi_r, lim_s;
  logic                     lim_on;
  logic [MUL_W-1:0]         kpmag_r, kimag_r;
  logic [MUL_W-1:0]         mul_a, mul_b;
  logic                     mul_neg;
  logic [OPB_W-1:0]         eop, pop;
  logic [2*MUL_W-1:0]       prod_r;
  logic                     prod_neg_r, prod_hi_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, acc_q;
  logic [ACC_W-1:0]         addend, addend_sg;
  logic                     psat_fit;
  logic signed [SAT_W-1:0]  psat_r, isum_r;
  logic signed [SUM_W-1:0]  isum_wide;
  logic signed [IW-1:0]     prop_r;
  logic [IW-1:0]            pmag_r;
  logic                     pneg_r;
  logic signed [CUR_W-1:0]  cmd_r, cmd_nxt;
  logic signed [IW-1:0]     integral_r, integ_nxt;
  logic signed [CUR_W-1:0]  last_r, last_nxt;
  out_item_t                out_r, res;
  logic                     sh, sl;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SERVO;
      kp_r    <= '0;
      ki_r    <= '0;
      lim_r   <= '0;
      cur_a_r <= '0;
      cur_b_r <= '0;
      wrap_r  <= 1'b0;
      hold_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:         mode_r  <= cfg_wdata[1:0];
        REG_PROP_GAIN:    kp_r    <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN:   ki_r    <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_LIMIT:  lim_r   <= cfg_wdata[LIM_W-1:0];
        REG_CURRENT_LOW:  cur_a_r <= cfg_wdata[CUR_W-1:0];
        REG_CURRENT_HIGH: cur_b_r <= cfg_wdata[CUR_W-1:0];
        REG_WRAP_ERROR:   wrap_r  <= cfg_wdata[0];
        REG_HOLD_CURRENT: hold_r  <= cfg_wdata[CUR_W-1:0];
        default:          wrap_r  <= wrap_r;
      endcase
    end
  end

  // Classify the word held in the input register
  always_comb begin
    if (in_r.op) begin
      kind = K_CLEAR;
    end else if (in_r.sample_time == '0) begin
      kind = K_STALE;
    end else if (mode_r == MODE_HOLD_REG) begin
      kind = K_HOLD_REG;
    end else if (mode_r != MODE_SERVO) begin
      kind = K_HOLD_LAST;
    end else if (!in_r.ref_valid || !in_r.meas_valid) begin
      kind = K_INVALID;
    end else begin
      kind = K_SERVO;
    end
  end
  assign stat.kind = kind;

  // Position error, optionally folded into one turn
  assign diff      = EW'(in_r.position_ref) - EW'(in_r.position_meas);
  assign diff_wrap = (diff <<< WRAP_SH) >>> WRAP_SH;
  assign err_nxt   = wrap_r ? diff_wrap : diff;

  // Integral bounds: the tighter of the width limit and the clamp register, unless the clamp register is zero
  assign lim_s  = signed'(IW'(lim_r));
  assign lim_on = (lim_r != '0) && (BW'(lim_r) <= BW'(IMAX));

  // Multiplier operand select
  assign eop = OPB_W'(emag_r);
  assign pop = OPB_W'(pmag_r);

  always_comb begin
    case (cmd.a_sel)
      MA_DT: begin
        mul_a   = MUL_W'(in_r.sample_time);
        mul_neg = eneg_r;
      end
      MA_KP: begin
        mul_a   = kpmag_r;
        mul_neg = kp_r[GAIN_W-1] ^ eneg_r;
      end
      MA_KI: begin
        mul_a   = kimag_r;
        mul_neg = ki_r[GAIN_W-1] ^ pneg_r;
      end
      default: begin
        mul_a   = '0;
        mul_neg = 1'b0;
      end
    endcase
    case (cmd.b_sel)
      MB_ERR_LO:  mul_b = eop[MUL_W-1:0];
      MB_ERR_HI:  mul_b = eop[OPB_W-1:MUL_W];
      MB_PROP_LO: mul_b = pop[MUL_W-1:0];
      MB_PROP_HI: mul_b = pop[OPB_W-1:MUL_W];
      default:    mul_b = '0;
    endcase
  end

  // Accumulate the signed, shifted partial product
  assign addend    = prod_hi_r ? ACC_W'({prod_r, {MUL_W{1'b0}}}) : ACC_W'(prod_r);
  assign addend_sg = prod_neg_r ? (~addend + ACC_W'(1)) : addend;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.step == ST_ERR || cmd.step == ST_PSAT) begin
      acc_nxt = '0;
    end else if (cmd.acc_add) begin
      acc_nxt = signed'(acc_r + addend_sg);
    end
  end

  // Step product saturated to the int64 range, then added with saturation
  assign psat_fit  = (&acc_r[ACC_W-1:SAT_W-1]) || !(|acc_r[ACC_W-1:SAT_W-1]);
  assign isum_wide = SUM_W'(integral_r) + SUM_W'(psat_r);

  // Command: arithmetic shift, then clamp to the current limits
  assign acc_q   = acc_r >>> OUT_SHIFT;
  assign cmd_nxt = (acc_q < ACC_W'(cmin_r)) ? cmin_r :
                   ((acc_q > ACC_W'(cmax_r)) ? cmax_r : CUR_W'(acc_q));

  // Result and state update at commit
  assign sh = (cmd_r >= cmax_r) && !err_r[EW-1] && (err_r != '0);
  assign sl = (cmd_r <= cmin_r) && err_r[EW-1];

  always_comb begin
    res       = '0;
    integ_nxt = integral_r;
    last_nxt  = last_r;
    unique case (kind)
      K_CLEAR: begin
        integ_nxt       = '0;
        res.current_ref = last_r;
      end
      K_STALE: begin
        res.current_ref = last_r;
        res.fallback    = 1'b1;
      end
      K_HOLD_REG: begin
        last_nxt        = clamp_cur(hold_r, cmin_r, cmax_r);
        res.current_ref = last_nxt;
      end
      K_HOLD_LAST: begin
        last_nxt        = clamp_cur(last_r, cmin_r, cmax_r);
        res.current_ref = last_nxt;
      end
      K_INVALID: begin
        last_nxt        = clamp_cur(last_r, cmin_r, cmax_r);
        res.current_ref = last_nxt;
        res.fallback    = 1'b1;
      end
      K_SERVO: begin
        last_nxt        = cmd_r;
        res.current_ref = cmd_r;
        res.sat_high    = sh;
        res.sat_low     = sl;
        if (!sh && !sl) integ_nxt = prop_r;
      end
      default: res.fallback = 1'b0;
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    acc_r <= acc_nxt;
    if (cmd.mul_en) begin
      prod_r     <= mul_a * mul_b;
      prod_neg_r <= mul_neg;
      prod_hi_r  <= (cmd.b_sel == MB_ERR_HI) || (cmd.b_sel == MB_PROP_HI);
    end
    case (cmd.step)
      ST_ERR: begin
        err_r   <= err_nxt;
        cmin_r  <= (cur_a_r < cur_b_r) ? cur_a_r : cur_b_r;
        cmax_r  <= (cur_a_r < cur_b_r) ? cur_b_r : cur_a_r;
        ihi_r   <= lim_on ? lim_s : IMAX;
        ilo_r   <= lim_on ? -lim_s : IMIN;
        kpmag_r <= kp_r[GAIN_W-1] ? unsigned'(-kp_r) : unsigned'(kp_r);
        kimag_r <= ki_r[GAIN_W-1] ? unsigned'(-ki_r) : unsigned'(ki_r);
      end
      ST_EMAG: begin
        eneg_r <= err_r[EW-1];
        emag_r <= err_r[EW-1] ? unsigned'(-err_r) : unsigned'(err_r);
      end
      ST_PSAT: begin
        psat_r <= psat_fit ? acc_r[SAT_W-1:0] : (acc_r[ACC_W-1] ? S_MIN : S_MAX);
      end
      ST_IADD: begin
        isum_r <= (isum_wide[SUM_W-1] != isum_wide[SUM_W-2]) ?
                  (isum_wide[SUM_W-1] ? S_MIN : S_MAX) : isum_wide[SAT_W-1:0];
      end
      ST_ICLAMP: begin
        prop_r <= (isum_r < SAT_W'(ilo_r)) ? ilo_r :
                  ((isum_r > SAT_W'(ihi_r)) ? ihi_r : IW'(isum_r));
      end
      ST_PMAG: begin
        pneg_r <= prop_r[IW-1];
        pmag_r <= prop_r[IW-1] ? unsigned'(-prop_r) : unsigned'(prop_r);
      end
      ST_CLAMP: cmd_r <= cmd_nxt;
      default:  cmd_r <= cmd_r;
    endcase
    if (cmd.commit) out_r <= res;
  end

  // Loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      last_r     <= '0;
    end else if (cmd.commit) begin
      integral_r <= integ_nxt;
      last_r     <= last_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== rtl/position_pi_current_reference.sv =====
// Position PI loop with conditional-integration anti-windup, producing a
// clamped current setpoint (Q16.16 amps) from a position reference and
// measurement. One word is worked on at a time. One shared 32x32 unsigned
// multiplier forms err*dt, kp*err and ki*integral as two 32-bit partial
// products each, and the step-product saturation, saturating integral add,
// integral clamp and output clamp each have a state of their own. Clear,
// hold, zero-step and invalid-input words skip the multiplier and go from
// S_ERR straight to S_SIMPLE. A finished word waits in the output register
// while the next word is accepted; commit stalls only if the previous result
// is still not taken. Configuration is written through cfg_we/cfg_addr/cfg_wdata
// by the user only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module position_pi_current_reference #(
  parameter int TURN_BITS   = pcr_pkg::TURN_BITS_DEF,
  parameter int INTEG_WIDTH = pcr_pkg::INTEG_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [pcr_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [pcr_pkg::CFG_DW-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire pcr_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output pcr_pkg::out_item_t              out_data
);
  import pcr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pcr_dpath #(
    .TURN_BITS   (TURN_BITS),
    .INTEG_WIDTH (INTEG_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // Never overwrite a result that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result committed over an untaken word");

  // One word in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

  // Saturation flags are exclusive
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.sat_high && out_data.sat_low))
    else $error("both saturation flags set");

  // A repeated command never reports saturation
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.fallback) |-> (!out_data.sat_high && !out_data.sat_low))
    else $error("fallback word with saturation flag");

endmodule

`default_nettype wire

// ===== test/pcr_setpoint_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts every current
// setpoint and compares the delivered words against the predictions in order.
module pcr_setpoint_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pcr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [pcr_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  pcr_pkg::in_item_t          in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  pcr_pkg::out_item_t         out_data,
  output int                         errors,
  output int                         pending
);
  import pcr_pkg::*;

  localparam longint INTEG_MAX = 64'sd140737488355327;

  // Shadow copy of the control registers
  logic [1:0]         mode_q;
  logic signed [31:0] kp_q;
  logic signed [31:0] ki_q;
  logic [46:0]        lim_q;
  logic signed [31:0] cur_a_q;
  logic signed [31:0] cur_b_q;
  logic               wrap_q;
  logic signed [31:0] hold_q;

  // Loop state
  longint integ_sum;
  longint last_setpoint;

  out_item_t setpoint_q[$];
  out_item_t want;
  int        fail_total = 0;

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Work out the setpoint word for one accepted request and advance the state
  function automatic out_item_t next_setpoint(in_item_t w);
    longint             lo, hi, err, dt, prop, lim, cmd;
    logic signed [15:0] turn_err;
    logic signed [127:0] kp_w, ki_w, err_w, prop_w, sum_w, lo_w, hi_w;
    out_item_t          r;
    r  = '0;
    lo = longint'((cur_a_q < cur_b_q) ? cur_a_q : cur_b_q);
    hi = longint'((cur_a_q < cur_b_q) ? cur_b_q : cur_a_q);
    dt = longint'(w.sample_time);
    if (w.op) begin
      integ_sum = 0;
      cmd = last_setpoint;
    end else if (dt == 0) begin
      cmd = last_setpoint;
      r.fallback = 1'b1;
    end else if (mode_q == MODE_HOLD_REG) begin
      cmd = clamp_range(longint'(hold_q), lo, hi);
      last_setpoint = cmd;
    end else if (mode_q != MODE_SERVO) begin
      cmd = clamp_range(last_setpoint, lo, hi);
      last_setpoint = cmd;
    end else if (!w.ref_valid || !w.meas_valid) begin
      cmd = clamp_range(last_setpoint, lo, hi);
      last_setpoint = cmd;
      r.fallback = 1'b1;
    end else begin
      err = longint'($signed(w.position_ref)) - longint'($signed(w.position_meas));
      // Shortest angle: keep the low turn bits, sign-extended
      if (wrap_q) begin
        turn_err = err[15:0];
        err = longint'(turn_err);
      end
      // Product stays far below 64 bits for these field widths
      prop = clamp_range(integ_sum + err * dt, -INTEG_MAX - 1, INTEG_MAX);
      lim = longint'(lim_q);
      if (lim > 0)
        prop = clamp_range(prop, -lim, lim);
      kp_w   = 128'(kp_q);
      ki_w   = 128'(ki_q);
      err_w  = 128'(err);
      prop_w = 128'(prop);
      lo_w   = 128'(lo);
      hi_w   = 128'(hi);
      sum_w  = (kp_w * err_w + ki_w * prop_w) >>> 24;
      if (sum_w < lo_w)
        cmd = lo;
      else if (sum_w > hi_w)
        cmd = hi;
      else
        cmd = sum_w[63:0];
      r.sat_high = (cmd >= hi) && (err > 0);
      r.sat_low  = (cmd <= lo) && (err < 0);
      // Conditional integration: hold the integral while pushing into a limit
      if (!r.sat_high && !r.sat_low)
        integ_sum = prop;
      last_setpoint = cmd;
    end
    r.current_ref = cmd[31:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    fail_total++;
    $display("%0t ns: %s expected %h, got %h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q        = MODE_SERVO;
      kp_q          = '0;
      ki_q          = '0;
      lim_q         = '0;
      cur_a_q       = '0;
      cur_b_q       = '0;
      wrap_q        = 1'b0;
      hold_q        = '0;
      integ_sum     = 0;
      last_setpoint = 0;
      setpoint_q.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_MODE:         mode_q  = cfg_wdata[1:0];
          REG_PROP_GAIN:    kp_q    = cfg_wdata[31:0];
          REG_INTEG_GAIN:   ki_q    = cfg_wdata[31:0];
          REG_INTEG_LIMIT:  lim_q   = cfg_wdata[46:0];
          REG_CURRENT_LOW:  cur_a_q = cfg_wdata[31:0];
          REG_CURRENT_HIGH: cur_b_q = cfg_wdata[31:0];
          REG_WRAP_ERROR:   wrap_q  = cfg_wdata[0];
          REG_HOLD_CURRENT: hold_q  = cfg_wdata[31:0];
          default: ;
        endcase
      end
      // Compare each delivered word with the oldest prediction
      if (out_valid && out_ready) begin
        if (setpoint_q.size() == 0) begin
          fail_total++;
          $display("%0t ns: word with none expected, got current_ref %h", $time,
                   out_data.current_ref);
        end else begin
          want = setpoint_q.pop_front();
          if (out_data.current_ref !== want.current_ref)
            flag_mismatch("current_ref", want.current_ref, out_data.current_ref);
          if (out_data.sat_high !== want.sat_high)
            flag_mismatch("sat_high", 32'(want.sat_high), 32'(out_data.sat_high));
          if (out_data.sat_low !== want.sat_low)
            flag_mismatch("sat_low", 32'(want.sat_low), 32'(out_data.sat_low));
          if (out_data.fallback !== want.fallback)
            flag_mismatch("fallback", 32'(want.fallback), 32'(out_data.fallback));
        end
      end
      // Predict the word for each accepted request
      if (in_valid && in_ready)
        setpoint_q.push_back(next_setpoint(in_data));
    end
    pending = setpoint_q.size();
    errors  = fail_total;
  end

endmodule

// ===== test/position_pi_current_reference_tb.sv =====
`timescale 1ns / 1ps

module position_pi_current_reference_tb;
  import pcr_pkg::*;

  localparam int         LIMIT_CYCLES = 500000;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] kp;
    logic [31:0] ki;
    logic [46:0] lim;
    logic [31:0] cur_a;
    logic [31:0] cur_b;
    logic        wrap;
    logic [31:0] hold;
  } ctrl_setting_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr = '0;
  logic [CFG_DW-1:0]  cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;

  int fail_cnt;
  int pending_cnt;
  int cycle_cnt = 0;
  int burst_left = 0;
  int squeeze_req = 0;
  int squeeze_done = 0;

  position_pi_current_reference uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pcr_setpoint_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (fail_cnt),
    .pending   (pending_cnt)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("position_pi_current_reference regression: fail");
      $finish;
    end
  end

  function automatic ctrl_setting_t mk_setting(logic [1:0] mode, logic [31:0] kp,
                                               logic [31:0] ki, logic [46:0] lim,
                                               logic [31:0] cur_a, logic [31:0] cur_b,
                                               logic wrap, logic [31:0] hold);
    ctrl_setting_t s;
    s.mode  = mode;
    s.kp    = kp;
    s.ki    = ki;
    s.lim   = lim;
    s.cur_a = cur_a;
    s.cur_b = cur_b;
    s.wrap  = wrap;
    s.hold  = hold;
    return s;
  endfunction

  function automatic in_item_t mk_word(logic op, logic [31:0] pos_ref, logic [31:0] act_pos,
                                       logic rv, logic mv, logic [23:0] dt);
    in_item_t w;
    w.op            = op;
    w.position_ref  = pos_ref;
    w.position_meas = act_pos;
    w.ref_valid     = rv;
    w.meas_valid    = mv;
    w.sample_time   = dt;
    return w;
  endfunction

  // Gains, currents: mostly spread magnitudes, sometimes the extremes
  function automatic logic [31:0] rand_scaled();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return $signed($urandom) >>> $urandom_range(4, 24);
    endcase
  endfunction

  function automatic ctrl_setting_t random_setting();
    ctrl_setting_t s;
    logic [63:0]   wide;
    case ($urandom_range(0, 7))
      0:       s.mode = MODE_HOLD_REG;
      1:       s.mode = MODE_HOLD_LAST;
      2:       s.mode = MODE_SPARE;
      default: s.mode = MODE_SERVO;
    endcase
    s.kp    = rand_scaled();
    s.ki    = rand_scaled();
    s.cur_a = rand_scaled();
    s.cur_b = rand_scaled();
    s.hold  = rand_scaled();
    s.wrap  = 1'($urandom_range(0, 1));
    wide    = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       s.lim = '0;
      1:       s.lim = 47'h7FFF_FFFF_FFFF;
      default: s.lim = wide[46:0] >> $urandom_range(10, 46);
    endcase
    return s;
  endfunction

  // Mostly valid servo steps with small errors so the integral builds up,
  // plus clears, invalid flags, zero steps and full-range positions
  function automatic in_item_t random_word();
    in_item_t    w;
    int          pick;
    logic [31:0] base, offs;
    pick = $urandom_range(0, 99);
    base = $urandom;
    case ($urandom_range(0, 3))
      0:       offs = $urandom;
      1:       offs = 32'h8000 + $urandom_range(0, 64) - 32;
      default: offs = $urandom_range(0, 4000) - 2000;
    endcase
    if ($urandom_range(0, 1))
      offs = -offs;
    w.op            = (pick < 4);
    w.position_meas = base;
    w.position_ref  = base + offs;
    w.ref_valid     = 1'b1;
    w.meas_valid    = 1'b1;
    if (pick < 4) begin
      w.ref_valid  = 1'($urandom_range(0, 1));
      w.meas_valid = 1'($urandom_range(0, 1));
    end else if (pick < 7) begin
      w.ref_valid  = 1'b0;
      w.meas_valid = 1'($urandom_range(0, 1));
    end else if (pick < 10) begin
      w.meas_valid = 1'b0;
      w.ref_valid  = 1'($urandom_range(0, 1));
    end
    if (pick >= 10 && pick < 14)
      w.sample_time = '0;
    else begin
      case ($urandom_range(0, 7))
        0:       w.sample_time = 24'($urandom_range(1, 24'hFF_FFFF));
        1:       w.sample_time = 24'hFF_FFFF;
        default: w.sample_time = 24'($urandom_range(1, 2000));
      endcase
    end
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_setting(input ctrl_setting_t s);
    write_reg(REG_MODE, CFG_DW'(s.mode));
    write_reg(REG_PROP_GAIN, CFG_DW'(s.kp));
    write_reg(REG_INTEG_GAIN, CFG_DW'(s.ki));
    write_reg(REG_INTEG_LIMIT, s.lim);
    write_reg(REG_CURRENT_LOW, CFG_DW'(s.cur_a));
    write_reg(REG_CURRENT_HIGH, CFG_DW'(s.cur_b));
    write_reg(REG_WRAP_ERROR, CFG_DW'(s.wrap));
    write_reg(REG_HOLD_CURRENT, CFG_DW'(s.hold));
    cfg_we <= 1'b0;
  endtask

  // Offer one word; open a new burst after a random gap when the last one ran out
  task automatic send_word(input in_item_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid, wait for every predicted word to arrive, then let the block settle
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_cnt != 0);
    repeat (tail) @(posedge clk);
  endtask

  // Result side: segments of steady, random or sparse ready, plus long hold-offs
  initial begin : result_sink
    int seg_len;
    int style;
    while (!rst_n) @(posedge clk);
    forever begin
      seg_len = $urandom_range(8, 120);
      style   = $urandom_range(0, 3);
      repeat (seg_len) begin
        if (squeeze_req != squeeze_done) begin
          out_ready <= 1'b0;
          repeat (300) @(posedge clk);
          squeeze_done++;
        end
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int ph;
    while (!rst_n) @(posedge clk);

    // Servo basics: clear, zero step, invalid flags, full-range errors, zero error
    load_setting(mk_setting(MODE_SERVO, 32'h0100_0000, 32'h0000_0400, 47'd0,
                            32'hFF9C_0000, 32'h0064_0000, 1'b0, 32'h0005_0000));
    send_word(mk_word(1'b1, 32'd123, 32'd456, 1'b1, 1'b1, 24'd10));
    send_word(mk_word(1'b0, 32'd1000, 32'd0, 1'b1, 1'b1, 24'd100));
    send_word(mk_word(1'b0, 32'd5, 32'd0, 1'b1, 1'b1, 24'd0));
    send_word(mk_word(1'b0, 32'd5, 32'd0, 1'b0, 1'b1, 24'd50));
    send_word(mk_word(1'b0, 32'd5, 32'd0, 1'b1, 1'b0, 24'd50));
    send_word(mk_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 24'hFF_FFFF));
    send_word(mk_word(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 24'hFF_FFFF));
    send_word(mk_word(1'b0, 32'd0, 32'd0, 1'b1, 1'b1, 24'd1));
    settle(4);

    // Extreme gains, swapped extreme limits, widest integral clamp, wrapped error
    load_setting(mk_setting(MODE_SERVO, 32'h8000_0000, 32'h7FFF_FFFF, 47'h7FFF_FFFF_FFFF,
                            32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF));
    send_word(mk_word(1'b0, 32'h0001_8000, 32'd0, 1'b1, 1'b1, 24'hFF_FFFF));
    send_word(mk_word(1'b0, 32'h0000_7FFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 24'd3));
    send_word(mk_word(1'b0, 32'hFFFF_0001, 32'h0000_0002, 1'b1, 1'b1, 24'd7));
    send_word(mk_word(1'b1, 32'd0, 32'd0, 1'b0, 1'b0, 24'd0));
    settle(4);

    // Small integral clamp that engages on the first of three steps
    load_setting(mk_setting(MODE_SERVO, 32'h0000_1000, 32'h0001_0000, 47'd5000,
                            32'hFFF0_0000, 32'h0010_0000, 1'b0, 32'd0));
    repeat (3) send_word(mk_word(1'b0, 32'd100, 32'd0, 1'b1, 1'b1, 24'd100));
    settle(4);

    // Hold the register current, clamped by the limit pair
    load_setting(mk_setting(MODE_HOLD_REG, 32'h0100_0000, 32'd0, 47'd0,
                            32'hFFFF_0000, 32'h0001_0000, 1'b0, 32'h7FFF_FFFF));
    send_word(mk_word(1'b0, 32'd9, 32'd1, 1'b0, 1'b0, 24'd7));
    send_word(mk_word(1'b0, 32'd9, 32'd1, 1'b1, 1'b1, 24'd0));
    settle(4);

    // Hold the last command under narrower limits, then the spare mode code
    load_setting(mk_setting(MODE_HOLD_LAST, 32'd0, 32'd0, 47'd0,
                            32'h0000_0400, 32'hFFFF_FC00, 1'b0, 32'h8000_0000));
    send_word(mk_word(1'b0, 32'd0, 32'd0, 1'b0, 1'b1, 24'd3));
    settle(4);
    load_setting(mk_setting(MODE_SPARE, 32'd0, 32'd0, 47'd0,
                            32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'd0));
    send_word(mk_word(1'b0, 32'd4, 32'd2, 1'b1, 1'b1, 24'd9));
    send_word(mk_word(1'b1, 32'd4, 32'd2, 1'b1, 1'b1, 24'd9));
    settle(4);

    // Random phases, each with a fresh register setting
    for (ph = 0; ph < 8; ph++) begin
      load_setting(random_setting());
      if (ph == 2 || ph == 5)
        squeeze_req++;
      repeat (100) send_word(random_word());
      settle(4);
    end

    settle(40);
    if (fail_cnt == 0)
      $display("position_pi_current_reference regression: pass");
    else
      $display("position_pi_current_reference regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pcr_pkg.sv
rtl/pcr_ctrl.sv
rtl/pcr_dpath.sv
rtl/position_pi_current_reference.sv
test/pcr_setpoint_checker.sv
test/position_pi_current_reference_tb.sv
